@@ design/clst_pkg.sv @@
// Shared types and codes for the circular list block.
`default_nettype none

package clst_pkg;

    localparam int REQ_TYPE_W    = 2;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_HEAD   = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_TAIL   = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic                load;
        logic                ins_write;
        logic                ins_link;
        logic                scan_step;
        logic                rm_unlink;
        logic                rm_advance;
        logic                st_load;
        logic [STATUS_W-1:0] st_code;
        logic                out_load;
    } clst_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic last_step;
        logic free_hit;
        logic out_free;
    } clst_sts_t;

endpackage

`default_nettype wire

@@ design/clst_req_if.sv @@
// Request channel: valid/ready handshake with operation and value.
`default_nettype none

interface clst_req_if;
    import clst_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [REQ_TYPE_W-1:0]      req_type;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

@@ design/clst_rsp_if.sv @@
// Response channel: valid/ready handshake with status and entry count.
`default_nettype none

interface clst_rsp_if;
    import clst_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_COUNT_W-1:0] entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

`default_nettype wire

@@ design/circular_list_insert_remove.sv @@
// Sequence, accept to result: an insert writes the entry and, unless the list was empty,
// links it behind the tail; it then scans for the next free slot unless it filled the list.
// A refused insert goes straight to the result. Remove compares entries one link per cycle,
// up to CAPACITY, and an empty list is answered without a walk. One item in flight; the next
// item is taken the cycle after the output register loads the result, after any output stall.
// Reset clears count, head, tail, free map and handshake state; the entry store is not cleared.
`default_nettype none

module circular_list_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    clst_req_if.sink    req,
    clst_rsp_if.source  rsp
);
    import clst_pkg::*;

    clst_cmd_t cmd;
    clst_sts_t sts;

    // Controller sequences each item: accept, insert write, tail link fix,
    // free-slot scan, or the remove walk, then hand-off to the result register.
    clst_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Datapath holds the entry store (value and link memories with registered
    // reads), free map, head/tail/count and the result register.
    clst_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_req_type     (req.req_type),
        .in_value        (req.value),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_status      (rsp.status),
        .out_entry_count (rsp.entry_count)
    );

endmodule

`default_nettype wire

@@ design/clst_ctrl.sv @@
// Controller state machine for the circular list block.
`default_nettype none

module clst_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [clst_pkg::REQ_TYPE_W-1:0]    in_req_type,
    output logic                               in_ready,
    input  clst_pkg::clst_sts_t                sts,
    output clst_pkg::clst_cmd_t                cmd
);
    import clst_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS    = 3'd1;
    localparam logic [2:0] S_LINK   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_RM_CMP = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_req_type)
                        REQ_HEAD, REQ_TAIL:
                        begin
                            state_next = S_INS;
                        end
                        REQ_REMOVE:
                        begin
                            if (sts.empty)
                            begin
                                cmd.st_load = 1'b1;
                                cmd.st_code = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RM_CMP;
                            end
                        end
                        default:
                        begin
                            // unused code: no change
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_OK;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                cmd.st_load = 1'b1;
                if (sts.full)
                begin
                    cmd.st_code = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.st_code   = ST_OK;
                    cmd.ins_write = 1'b1;
                    state_next    = sts.empty ? S_SCAN : S_LINK;
                end
            end
            S_LINK:
            begin
                cmd.ins_link = 1'b1;
                // count already bumped: full means no free slot left to find
                state_next   = sts.full ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.free_hit)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RM_CMP:
            begin
                if (sts.match)
                begin
                    cmd.rm_unlink = 1'b1;
                    cmd.st_load   = 1'b1;
                    cmd.st_code   = ST_OK;
                    state_next    = S_DONE;
                end
                else if (sts.last_step)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rm_advance = 1'b1;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ design/clst_dpath.sv @@
// Datapath: entry store, links, free map, list pointers and result register.
`default_nettype none

module clst_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [clst_pkg::REQ_TYPE_W-1:0]       in_req_type,
    input  logic signed [clst_pkg::VALUE_W-1:0]   in_value,
    input  clst_pkg::clst_cmd_t                   cmd,
    output clst_pkg::clst_sts_t                   sts,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [clst_pkg::STATUS_W-1:0]         out_status,
    output logic [clst_pkg::ENTRY_COUNT_W-1:0]    out_entry_count
);
    import clst_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // entry store, no reset
    logic [VALUE_W-1:0] val_mem  [CAPACITY];
    logic [IDX_W-1:0]   link_mem [CAPACITY];
    logic [VALUE_W-1:0] rd_value_reg;
    logic [IDX_W-1:0]   rd_link_reg;

    logic [REQ_TYPE_W-1:0] req_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [IDX_W-1:0]      cur_reg;
    logic [IDX_W-1:0]      prev_reg;
    logic [CNT_W-1:0]      steps_reg;
    logic [STATUS_W-1:0]   st_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      first_reg;
    logic [IDX_W-1:0]      last_reg;
    logic [CAPACITY-1:0]   free_reg;
    logic [IDX_W-1:0]      lfree_reg;   // lowest free entry while not full
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [ENTRY_COUNT_W-1:0] out_count_reg;

    logic                  empty;
    logic                  full;
    logic                  single;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    logic [IDX_W-1:0]      link_wdata;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign single = (count_reg == CNT_W'(1));

    assign sts.empty     = empty;
    assign sts.full      = full;
    assign sts.match     = (rd_value_reg == value_reg);
    assign sts.last_step = (CNT_W'(steps_reg + 1'b1) == count_reg);
    assign sts.free_hit  = free_reg[lfree_reg];
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign rd_en   = cmd.load || cmd.rm_advance;
    assign rd_addr = cmd.load ? first_reg : rd_link_reg;

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = lfree_reg;
        link_wdata = empty ? lfree_reg : first_reg;
        if (cmd.ins_write)
        begin
            link_we = 1'b1;
        end
        else if (cmd.ins_link)
        begin
            link_we    = 1'b1;
            link_waddr = last_reg;
            link_wdata = slot_reg;
        end
        else if (cmd.rm_unlink && !single)
        begin
            link_we    = 1'b1;
            link_waddr = prev_reg;
            link_wdata = rd_link_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
        begin
            val_mem[lfree_reg] <= value_reg;
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (rd_en)
        begin
            rd_value_reg <= val_mem[rd_addr];
            rd_link_reg  <= link_mem[rd_addr];
        end
    end

    // request payload and walk pointers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= in_req_type;
            value_reg <= in_value;
            cur_reg   <= first_reg;
            prev_reg  <= last_reg;
            steps_reg <= '0;
        end
        if (cmd.rm_advance)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= rd_link_reg;
            steps_reg <= CNT_W'(steps_reg + 1'b1);
        end
        if (cmd.ins_write)
        begin
            slot_reg <= lfree_reg;
        end
        if (cmd.st_load)
        begin
            st_reg <= cmd.st_code;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= st_reg;
            out_count_reg  <= ENTRY_COUNT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            free_reg      <= '1;
            lfree_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins_write)
            begin
                free_reg[lfree_reg] <= 1'b0;
                count_reg           <= CNT_W'(count_reg + 1'b1);
                if (empty)
                begin
                    first_reg <= lfree_reg;
                    last_reg  <= lfree_reg;
                end
            end
            if (cmd.ins_link)
            begin
                if (req_reg == REQ_HEAD)
                begin
                    first_reg <= slot_reg;
                end
                else
                begin
                    last_reg <= slot_reg;
                end
            end
            if (cmd.scan_step)
            begin
                lfree_reg <= IDX_W'(lfree_reg + 1'b1);
            end
            if (cmd.rm_unlink)
            begin
                free_reg[cur_reg] <= 1'b1;
                count_reg         <= CNT_W'(count_reg - 1'b1);
                if (full || (cur_reg < lfree_reg))
                begin
                    lfree_reg <= cur_reg;
                end
                if (single)
                begin
                    first_reg <= '0;
                    last_reg  <= '0;
                end
                else
                begin
                    if (cur_reg == first_reg)
                    begin
                        first_reg <= rd_link_reg;
                    end
                    if (cur_reg == last_reg)
                    begin
                        last_reg <= prev_reg;
                    end
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_entry_count = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_free_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(free_reg) + int'(count_reg)) == CAPACITY)
        else $error("free map and entry count disagree");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (first_reg == '0 && last_reg == '0))
        else $error("empty list with nonzero head or tail");

    a_single_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        single |-> (first_reg == last_reg))
        else $error("single entry with head and tail apart");
`endif

endmodule

`default_nettype wire

@@ dv/circular_list_insert_remove_tb.sv @@
// Testbench for circular_list_insert_remove: directed and random list requests, scoreboard check.
`default_nettype none

module circular_list_insert_remove_tb;
    import clst_pkg::*;

    localparam int CAPACITY = 16;

    // Selector code the block does not define; it must change nothing.
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1100;
    // Random items during which neither side idles.
    localparam int CALM_FIRST   = 300;
    localparam int CALM_LAST    = 500;
    // Random item at which the response side starts its long hold-off.
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 300;
    // Drain well past the longest item.
    localparam int DRAIN_CYCLES = 60;
    // Cycles with no handshake on either side before the run is declared hung.
    localparam int STALL_LIMIT  = 3000;

    // Expected content of one response item.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } outcome_t;

    // Mirror of the linked store plus the queue of outcomes still owed by the block.
    class list_scoreboard;
        logic [VALUE_W-1:0] slot_value [CAPACITY];
        int                 slot_next  [CAPACITY];
        bit                 slot_free  [CAPACITY];
        int                 head_slot;
        int                 tail_slot;
        int                 held;
        outcome_t           expected_outcomes [$];
        int                 errors;

        function new();
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_value[i] = '0;
                slot_next[i]  = 0;
                slot_free[i]  = 1'b1;
            end
            head_slot = 0;
            tail_slot = 0;
            held      = 0;
            errors    = 0;
        endfunction

        // Applies one request to the mirror and returns what the block must answer.
        function outcome_t predict_outcome(logic [REQ_TYPE_W-1:0] op, logic [VALUE_W-1:0] v);
            outcome_t res;
            int       s;
            int       prev;
            int       cur;
            int       walk;
            int       step;
            bit       found;
            res.status = ST_OK;
            case (op)
                REQ_HEAD, REQ_TAIL:
                begin
                    if (held >= CAPACITY)
                        res.status = ST_FULL;
                    else
                    begin
                        // lowest free slot
                        s = 0;
                        while (!slot_free[s])
                            s++;
                        slot_free[s]  = 1'b0;
                        slot_value[s] = v;
                        if (held == 0)
                        begin
                            slot_next[s] = s;
                            head_slot    = s;
                            tail_slot    = s;
                        end
                        else
                        begin
                            slot_next[s]         = head_slot;
                            slot_next[tail_slot] = s;
                            if (op == REQ_HEAD)
                                head_slot = s;
                            else
                                tail_slot = s;
                        end
                        held++;
                    end
                end
                REQ_REMOVE:
                begin
                    if (held == 0)
                        res.status = ST_EMPTY;
                    else
                    begin
                        res.status = ST_NOT_FOUND;
                        prev  = tail_slot;
                        cur   = head_slot;
                        walk  = held;
                        found = 1'b0;
                        for (step = 0; step < walk && !found; step++)
                        begin
                            if (slot_value[cur] == v)
                            begin
                                found = 1'b1;
                                if (held == 1)
                                begin
                                    head_slot = 0;
                                    tail_slot = 0;
                                end
                                else
                                begin
                                    slot_next[prev] = slot_next[cur];
                                    if (cur == head_slot)
                                        head_slot = slot_next[cur];
                                    if (cur == tail_slot)
                                        tail_slot = prev;
                                end
                                // the matched slot goes back to the pool, not the head
                                slot_free[cur] = 1'b1;
                                held--;
                                res.status = ST_OK;
                            end
                            else
                            begin
                                prev = cur;
                                cur  = slot_next[cur];
                            end
                        end
                    end
                end
                default: ;
            endcase
            res.entry_count = held[ENTRY_COUNT_W-1:0];
            return res;
        endfunction

        function void note_request(logic [REQ_TYPE_W-1:0] op, logic [VALUE_W-1:0] v);
            expected_outcomes.push_back(predict_outcome(op, v));
        endfunction

        function void check_response(logic [STATUS_W-1:0] st, logic [ENTRY_COUNT_W-1:0] cnt);
            outcome_t exp_res;
            if (expected_outcomes.size() == 0)
            begin
                $error("response with no request outstanding: status %0d entry_count %0d",
                       st, cnt);
                errors++;
            end
            else
            begin
                exp_res = expected_outcomes.pop_front();
                if (st !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_res.status, st);
                    errors++;
                end
                if (cnt !== exp_res.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d", exp_res.entry_count, cnt);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    clst_req_if req_ch ();
    clst_rsp_if rsp_ch ();

    circular_list_insert_remove #(.CAPACITY(CAPACITY)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_scoreboard sb = new();

    // Shared stimulus controls: calm turns off idling on both sides,
    // hold_request starts the one long response hold-off.
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Small value set so the list collects duplicates and removes hit often.
    // Includes both signed extremes, zero and all ones.
    function automatic logic [VALUE_W-1:0] pool_value(int k);
        case (k % 8)
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return 32'hAAAA_5555;
            6:       return 32'h5555_AAAA;
            default: return 32'h0000_002A;
        endcase
    endfunction

    // Offer one item: random idle cycles first, then hold valid until accepted.
    // Entered and left at a falling edge.
    task automatic offer_request(input logic [REQ_TYPE_W-1:0] op, input logic [VALUE_W-1:0] v);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.value    <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Scoreboard taps: both channels sampled at the rising edge. A request and
    // the previous item's response can complete on the same edge; noting the
    // request first keeps the queue in order since the response is older.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.req_type, req_ch.value);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.entry_count);
        end
    end

    // Response side: random back-pressure, none during the calm stretch, and
    // one long hold-off so the block fills and stalls its request side.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    // Hang detector: counts cycles in which neither channel completes a handshake.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $error("no handshake for %0d cycles", STALL_LIMIT);
        $display("circular_list_insert_remove_tb: FAIL");
        $finish;
    end

    initial
    begin
        logic [REQ_TYPE_W-1:0] op;
        logic [VALUE_W-1:0]    v;
        int                    roll;
        int                    cur;
        int                    hops;
        bit                    growing;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_HEAD;
        req_ch.value    = '0;
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // Empty list: remove reports empty, unused selector is a no-op.
        offer_request(REQ_REMOVE, 32'h0000_0000);
        offer_request(REQ_UNUSED, 32'hFFFF_FFFF);

        // Fill to capacity alternating head and tail inserts; the pool repeats
        // after eight, so every value is held twice.
        for (int i = 0; i < CAPACITY; i++)
            offer_request((i % 2 == 0) ? REQ_HEAD : REQ_TAIL, pool_value(i));

        // Full list: both inserts refused, unused selector still a no-op.
        offer_request(REQ_HEAD, 32'h1357_9BDF);
        offer_request(REQ_TAIL, 32'h2468_ACE0);
        offer_request(REQ_UNUSED, 32'h8000_0000);

        // Search misses, then duplicate match (first from head wins),
        // then the head value and the tail value.
        offer_request(REQ_REMOVE, 32'h1234_5678);
        offer_request(REQ_REMOVE, pool_value(0));
        offer_request(REQ_REMOVE, pool_value(CAPACITY - 2));
        offer_request(REQ_REMOVE, pool_value(CAPACITY - 1));

        // ---- random part ----
        // The op mix swings between a growing and a shrinking phase so the list
        // keeps passing through full and empty, and through single-entry removal.
        growing = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            if (n == HOLD_AT)
                hold_request = 1'b1;

            if (sb.held == 0)
                growing = 1'b1;
            else if (sb.held == CAPACITY && $urandom_range(0, 3) == 0)
                growing = 1'b0;

            roll = $urandom_range(0, 99);
            if (roll < 5)
                op = REQ_UNUSED;
            else if (roll < (growing ? 75 : 30))
                op = $urandom_range(0, 1) ? REQ_TAIL : REQ_HEAD;
            else
                op = REQ_REMOVE;

            if (op == REQ_REMOVE && sb.held > 0 && $urandom_range(0, 99) < 75)
            begin
                // pick a value that is in the list, at a random position
                hops = $urandom_range(0, sb.held - 1);
                cur  = sb.head_slot;
                for (int h = 0; h < hops; h++)
                    cur = sb.slot_next[cur];
                v = sb.slot_value[cur];
            end
            else if ($urandom_range(0, 99) < 60)
                v = pool_value($urandom_range(0, 7));
            else
                v = $urandom;

            offer_request(op, v);
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        // Drain: wait for every owed response, then watch for strays.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("circular_list_insert_remove_tb: PASS");
        else
            $display("circular_list_insert_remove_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
design/clst_pkg.sv
design/clst_req_if.sv
design/clst_rsp_if.sv
design/clst_ctrl.sv
design/clst_dpath.sv
design/circular_list_insert_remove.sv
dv/circular_list_insert_remove_tb.sv
